/* design/nsq_pkg.sv */
// Shared types, constants and helper functions of the nine-slice quad generator.
package nsq_pkg;

   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;
   localparam int ProdW    = 41;
   localparam int QuotW    = 18;
   localparam int StepCnt  = QuotW / 2;
   localparam int StepW    = 4;
   localparam int LaneCnt  = 4;

   localparam logic [1:0] LaneLeft   = 2'd0;
   localparam logic [1:0] LaneRight  = 2'd1;
   localparam logic [1:0] LaneTop    = 2'd2;
   localparam logic [1:0] LaneBottom = 2'd3;

   localparam logic [3:0]  CenterPart = 4'd4;
   localparam logic [3:0]  LastPart   = 4'd8;
   localparam logic [16:0] UvOne      = 17'd65536;

   typedef enum logic [2:0] {
      CsrBorderLeft   = 3'd0,
      CsrBorderRight  = 3'd1,
      CsrBorderTop    = 3'd2,
      CsrBorderBottom = 3'd3,
      CsrTexWidth     = 3'd4,
      CsrTexHeight    = 3'd5,
      CsrFillCenter   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [23:0] border_left;
      logic [23:0] border_right;
      logic [23:0] border_top;
      logic [23:0] border_bottom;
      logic [15:0] tex_width;
      logic [15:0] tex_height;
      logic        fill_center;
   } cfg_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [23:0]        width;
      logic [23:0]        height;
      logic [16:0]        uv_left;
      logic [16:0]        uv_right;
      logic [16:0]        uv_top;
      logic [16:0]        uv_bottom;
      logic               has_texture;
   } req_type;

   typedef struct packed {
      logic [3:0]         part_index;
      logic               last_part;
      logic               render;
      logic signed [23:0] part_x;
      logic signed [23:0] part_y;
      logic [23:0]        part_w;
      logic [23:0]        part_h;
      logic [16:0]        uv_min_u;
      logic [16:0]        uv_min_v;
      logic [16:0]        uv_max_u;
      logic [16:0]        uv_max_v;
   } rsp_type;

   // One classified placement, waiting for the UV divisions.
   typedef struct packed {
      logic signed [23:0]              pos_x;
      logic signed [23:0]              pos_y;
      logic signed [23:0]              x_mid;
      logic signed [23:0]              x_far;
      logic signed [23:0]              y_mid;
      logic signed [23:0]              y_far;
      logic [23:0]                     border_left;
      logic [23:0]                     center_w;
      logic [23:0]                     border_right;
      logic [23:0]                     border_top;
      logic [23:0]                     center_h;
      logic [23:0]                     border_bottom;
      logic [16:0]                     uv_left;
      logic [16:0]                     uv_right;
      logic [16:0]                     uv_top;
      logic [16:0]                     uv_bottom;
      logic                            valid;
      logic [LaneCnt-1:0][ProdW-1:0]   prod_mag;
      logic [LaneCnt-1:0]              prod_neg;
      logic [23:0]                     den_u;
      logic [23:0]                     den_v;
   } job_type;

   typedef struct packed {
      job_type                         job;
      logic [LaneCnt-1:0][QuotW-1:0]   quot;
   } div_out_type;

   function automatic logic signed [23:0] sat_pos(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'sd8388607) r = 24'sh7FFFFF;
      else if (v < -27'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

   function automatic logic [16:0] clamp_uv(input logic signed [20:0] v);
      logic [16:0] r;
      if (v < 21'sd0) r = '0;
      else if (v > 21'sd65536) r = UvOne;
      else r = v[16:0];
      return r;
   endfunction

   function automatic logic [16:0] sat_uv_in(input logic [16:0] v);
      return (v > UvOne) ? UvOne : v;
   endfunction

endpackage

/* design/nsq_front.sv */
// Front end: classifies a placement, forms the UV products and queues the job.
module nsq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  nsq_pkg::req_type req_data,
   input  nsq_pkg::cfg_type cfg,
   output logic             job_valid,
   input  logic             job_take,
   output nsq_pkg::job_type job
);

   nsq_pkg::job_type   q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   nsq_pkg::job_type   new_job;
   logic               push_ok, pop_ok;

   logic [16:0]        ul, ur, ut, ub;
   logic signed [17:0] span_u, span_v;
   logic [16:0]        mag_u, mag_v;
   logic signed [25:0] cw_sum, ch_sum;
   logic [23:0]        cw, ch;

   always_comb begin
      ul = nsq_pkg::sat_uv_in(req_data.uv_left);
      ur = nsq_pkg::sat_uv_in(req_data.uv_right);
      ut = nsq_pkg::sat_uv_in(req_data.uv_top);
      ub = nsq_pkg::sat_uv_in(req_data.uv_bottom);
      span_u = $signed({1'b0, ur}) - $signed({1'b0, ul});
      span_v = $signed({1'b0, ub}) - $signed({1'b0, ut});
      mag_u = span_u[17] ? 17'(-span_u) : span_u[16:0];
      mag_v = span_v[17] ? 17'(-span_v) : span_v[16:0];
      cw_sum = $signed({2'b0, req_data.width}) - $signed({2'b0, cfg.border_left})
             - $signed({2'b0, cfg.border_right});
      ch_sum = $signed({2'b0, req_data.height}) - $signed({2'b0, cfg.border_top})
             - $signed({2'b0, cfg.border_bottom});
      cw = cw_sum[25] ? '0 : cw_sum[23:0];
      ch = ch_sum[25] ? '0 : ch_sum[23:0];

      new_job.pos_x = req_data.pos_x;
      new_job.pos_y = req_data.pos_y;
      new_job.x_mid = nsq_pkg::sat_pos($signed({{3{req_data.pos_x[23]}}, req_data.pos_x})
                      + $signed({3'b0, cfg.border_left}));
      new_job.x_far = nsq_pkg::sat_pos($signed({{3{req_data.pos_x[23]}}, req_data.pos_x})
                      + $signed({3'b0, cfg.border_left}) + $signed({3'b0, cw}));
      new_job.y_mid = nsq_pkg::sat_pos($signed({{3{req_data.pos_y[23]}}, req_data.pos_y})
                      + $signed({3'b0, cfg.border_top}));
      new_job.y_far = nsq_pkg::sat_pos($signed({{3{req_data.pos_y[23]}}, req_data.pos_y})
                      + $signed({3'b0, cfg.border_top}) + $signed({3'b0, ch}));
      new_job.border_left   = cfg.border_left;
      new_job.center_w      = cw;
      new_job.border_right  = cfg.border_right;
      new_job.border_top    = cfg.border_top;
      new_job.center_h      = ch;
      new_job.border_bottom = cfg.border_bottom;
      new_job.uv_left   = ul;
      new_job.uv_right  = ur;
      new_job.uv_top    = ut;
      new_job.uv_bottom = ub;
      new_job.valid = (req_data.width != '0) && (req_data.height != '0);
      new_job.prod_mag[nsq_pkg::LaneLeft]   = 41'(cfg.border_left) * 41'(mag_u);
      new_job.prod_mag[nsq_pkg::LaneRight]  = 41'(cfg.border_right) * 41'(mag_u);
      new_job.prod_mag[nsq_pkg::LaneTop]    = 41'(cfg.border_top) * 41'(mag_v);
      new_job.prod_mag[nsq_pkg::LaneBottom] = 41'(cfg.border_bottom) * 41'(mag_v);
      new_job.prod_neg[nsq_pkg::LaneLeft]   = span_u[17];
      new_job.prod_neg[nsq_pkg::LaneRight]  = span_u[17];
      new_job.prod_neg[nsq_pkg::LaneTop]    = span_v[17];
      new_job.prod_neg[nsq_pkg::LaneBottom] = span_v[17];
      // Texture size in 16.8 pixels, or the placement size without a texture; a zero size counts as one.
      if (req_data.has_texture) begin
         new_job.den_u = {(cfg.tex_width == '0) ? 16'd1 : cfg.tex_width, 8'h00};
         new_job.den_v = {(cfg.tex_height == '0) ? 16'd1 : cfg.tex_height, 8'h00};
      end else begin
         new_job.den_u = (req_data.width == '0) ? 24'd1 : req_data.width;
         new_job.den_v = (req_data.height == '0) ? 24'd1 : req_data.height;
      end
   end

   assign req_full  = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_take && job_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ptr_ff] <= new_job;
   end

endmodule

/* design/nsq_divider.sv */
// Four-lane radix-4 restoring divider for the inner UV offsets.
module nsq_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_take,
   input  nsq_pkg::job_type     job,
   output logic                 done,
   input  logic                 take,
   output nsq_pkg::div_out_type result
);

   localparam int LaneCnt = nsq_pkg::LaneCnt;
   localparam int ProdW   = nsq_pkg::ProdW;
   localparam int QuotW   = nsq_pkg::QuotW;

   logic                             busy_ff, busy_in;
   logic [nsq_pkg::StepW-1:0]        step_ff, step_in;
   nsq_pkg::job_type                 job_ff;
   logic [LaneCnt-1:0][ProdW-1:0]    rem_ff, rem_in;
   logic [LaneCnt-1:0][ProdW-1:0]    dsh_ff, dsh_in;
   logic [LaneCnt-1:0][QuotW-1:0]    quot_ff, quot_in;
   logic [LaneCnt-1:0]               ovf_ff, ovf_in;
   logic                             load;
   logic [ProdW-1:0]                 rem_a, dsh_b;
   logic                             bit_a, bit_b;
   logic [23:0]                      den;

   assign done     = busy_ff && (step_ff == '0);
   assign load     = job_valid && (!busy_ff || (done && take));
   assign job_take = load;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = nsq_pkg::StepW'(nsq_pkg::StepCnt);
      end else if (done && take) begin
         busy_in = 1'b0;
      end else if (busy_ff && step_ff != '0) begin
         step_in = step_ff - 1'b1;
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      rem_a   = '0;
      dsh_b   = '0;
      bit_a   = 1'b0;
      bit_b   = 1'b0;
      den     = '0;
      for (int i = 0; i < LaneCnt; i++) begin
         if (load) begin
            den = (i < 2) ? job.den_u : job.den_v;
            // Quotients past 18 bits clamp the cut anyway: saturate them.
            ovf_in[i]  = {1'b0, job.prod_mag[i]} >= {den, 18'b0};
            rem_in[i]  = job.prod_mag[i];
            dsh_in[i]  = {den, 17'b0};
            quot_in[i] = '0;
         end else if (busy_ff && step_ff != '0) begin
            bit_a = rem_ff[i] >= dsh_ff[i];
            rem_a = bit_a ? rem_ff[i] - dsh_ff[i] : rem_ff[i];
            dsh_b = dsh_ff[i] >> 1;
            bit_b = rem_a >= dsh_b;
            rem_in[i]  = bit_b ? rem_a - dsh_b : rem_a;
            dsh_in[i]  = dsh_ff[i] >> 2;
            quot_in[i] = {quot_ff[i][QuotW-3:0], bit_a, bit_b};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) job_ff <= job;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   always_comb begin
      result.job = job_ff;
      for (int i = 0; i < LaneCnt; i++) begin
         result.quot[i] = ovf_ff[i] ? '1 : quot_ff[i];
      end
   end

endmodule

/* design/nsq_emitter.sv */
// Back end: forms the UV cuts and walks the nine quads into the result register.
module nsq_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 done,
   output logic                 take,
   input  nsq_pkg::div_out_type result,
   input  logic                 fill_center,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output nsq_pkg::rsp_type     rsp_data
);

   logic                      active_ff, active_in;
   logic [1:0]                col_ff, col_in;
   logic [1:0]                row_ff, row_in;
   logic [3:0]                index_ff, index_in;
   logic signed [23:0]        x_ff [3];
   logic signed [23:0]        y_ff [3];
   logic [23:0]               w_ff [3];
   logic [23:0]               h_ff [3];
   logic [16:0]               u_ff [4];
   logic [16:0]               v_ff [4];
   logic                      valid_ff;
   logic                      out_valid_ff, out_valid_in;
   nsq_pkg::rsp_type          out_ff, quad;
   logic                      adv, last, load;
   logic signed [20:0]        off [nsq_pkg::LaneCnt];
   logic [16:0]               cut_l, cut_r, cut_t, cut_b;

   assign adv  = active_ff && (!out_valid_ff || rsp_pop);
   assign last = (index_ff == nsq_pkg::LastPart);
   assign load = done && (!active_ff || (adv && last));
   assign take = load;

   always_comb begin
      for (int i = 0; i < nsq_pkg::LaneCnt; i++) begin
         off[i] = result.job.prod_neg[i] ? -$signed({3'b0, result.quot[i]})
                                         : $signed({3'b0, result.quot[i]});
      end
      cut_l = nsq_pkg::clamp_uv($signed({4'b0, result.job.uv_left}) + off[nsq_pkg::LaneLeft]);
      cut_r = nsq_pkg::clamp_uv($signed({4'b0, result.job.uv_right}) - off[nsq_pkg::LaneRight]);
      cut_t = nsq_pkg::clamp_uv($signed({4'b0, result.job.uv_top}) + off[nsq_pkg::LaneTop]);
      cut_b = nsq_pkg::clamp_uv($signed({4'b0, result.job.uv_bottom})
                                - off[nsq_pkg::LaneBottom]);
   end

   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      index_in  = index_ff;
      if (load) begin
         active_in = 1'b1;
         col_in    = '0;
         row_in    = '0;
         index_in  = '0;
      end else if (adv) begin
         // Advance row-major; drop out after the ninth quad.
         if (last) active_in = 1'b0;
         index_in = index_ff + 1'b1;
         if (col_ff == 2'd2) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      quad.part_index = index_ff;
      quad.last_part  = last;
      quad.render     = valid_ff && (w_ff[col_ff] != '0) && (h_ff[row_ff] != '0)
                        && !(index_ff == nsq_pkg::CenterPart && !fill_center);
      if (valid_ff) begin
         quad.part_x   = x_ff[col_ff];
         quad.part_y   = y_ff[row_ff];
         quad.part_w   = w_ff[col_ff];
         quad.part_h   = h_ff[row_ff];
         quad.uv_min_u = u_ff[col_ff];
         quad.uv_min_v = v_ff[row_ff];
         quad.uv_max_u = u_ff[col_ff + 2'd1];
         quad.uv_max_v = v_ff[row_ff + 2'd1];
      end else begin
         quad.part_x   = '0;
         quad.part_y   = '0;
         quad.part_w   = '0;
         quad.part_h   = '0;
         quad.uv_min_u = '0;
         quad.uv_min_v = '0;
         quad.uv_max_u = '0;
         quad.uv_max_v = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (adv) out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         index_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         index_ff     <= index_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff[0] <= result.job.pos_x;
         x_ff[1] <= result.job.x_mid;
         x_ff[2] <= result.job.x_far;
         y_ff[0] <= result.job.pos_y;
         y_ff[1] <= result.job.y_mid;
         y_ff[2] <= result.job.y_far;
         w_ff[0] <= result.job.border_left;
         w_ff[1] <= result.job.center_w;
         w_ff[2] <= result.job.border_right;
         h_ff[0] <= result.job.border_top;
         h_ff[1] <= result.job.center_h;
         h_ff[2] <= result.job.border_bottom;
         u_ff[0] <= result.job.uv_left;
         u_ff[1] <= cut_l;
         u_ff[2] <= cut_r;
         u_ff[3] <= result.job.uv_right;
         v_ff[0] <= result.job.uv_top;
         v_ff[1] <= cut_t;
         v_ff[2] <= cut_b;
         v_ff[3] <= result.job.uv_bottom;
         valid_ff <= result.job.valid;
      end
      if (adv) out_ff <= quad;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* design/nine_slice_quad_generator_unit.sv */
// Top level of the nine-slice quad generator: register file and front/back hookup.
//
//   channel   ports                       direction  word
//   req       req_push/req_full/req_data  in         one sprite placement
//   rsp       rsp_pop/rsp_empty/rsp_data  out        one quad, nine per placement
//   csr       csr_p*                      in/out     register write and read
//
// At sustained rate the divider sets the pace of placements: a load, then
// nine radix-4 steps for the four UV offsets. A placement's nine quads leave
// at one a cycle while the result register is popped and the next one divides.
// Reset is synchronous and clears all queues; a full result register stalls
// the back end, which holds the divider and in turn the request queue.
module nine_slice_quad_generator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  nsq_pkg::req_type                req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output nsq_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nsq_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [nsq_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [nsq_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                            csr_pready
);

   nsq_pkg::cfg_type      cfg_ff, cfg_in;
   nsq_pkg::csr_index_type csr_index;
   logic                  csr_write;
   logic                  job_valid, job_take;
   nsq_pkg::job_type      job;
   logic                  div_done, div_take;
   nsq_pkg::div_out_type  div_result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = nsq_pkg::csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            nsq_pkg::CsrBorderLeft:   cfg_in.border_left   = csr_pwdata[23:0];
            nsq_pkg::CsrBorderRight:  cfg_in.border_right  = csr_pwdata[23:0];
            nsq_pkg::CsrBorderTop:    cfg_in.border_top    = csr_pwdata[23:0];
            nsq_pkg::CsrBorderBottom: cfg_in.border_bottom = csr_pwdata[23:0];
            nsq_pkg::CsrTexWidth:     cfg_in.tex_width     = csr_pwdata[15:0];
            nsq_pkg::CsrTexHeight:    cfg_in.tex_height    = csr_pwdata[15:0];
            nsq_pkg::CsrFillCenter:   cfg_in.fill_center   = csr_pwdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         nsq_pkg::CsrBorderLeft:   csr_prdata = {8'b0, cfg_ff.border_left};
         nsq_pkg::CsrBorderRight:  csr_prdata = {8'b0, cfg_ff.border_right};
         nsq_pkg::CsrBorderTop:    csr_prdata = {8'b0, cfg_ff.border_top};
         nsq_pkg::CsrBorderBottom: csr_prdata = {8'b0, cfg_ff.border_bottom};
         nsq_pkg::CsrTexWidth:     csr_prdata = {16'b0, cfg_ff.tex_width};
         nsq_pkg::CsrTexHeight:    csr_prdata = {16'b0, cfg_ff.tex_height};
         nsq_pkg::CsrFillCenter:   csr_prdata = {31'b0, cfg_ff.fill_center};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.border_left   <= '0;
         cfg_ff.border_right  <= '0;
         cfg_ff.border_top    <= '0;
         cfg_ff.border_bottom <= '0;
         cfg_ff.tex_width     <= 16'd1;
         cfg_ff.tex_height    <= 16'd1;
         cfg_ff.fill_center   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job)
   );

   nsq_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job),
      .done      (div_done),
      .take      (div_take),
      .result    (div_result)
   );

   nsq_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .done        (div_done),
      .take        (div_take),
      .result      (div_result),
      .fill_center (cfg_ff.fill_center),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

/* design/nsq_checker.sv */
// Port-level checks of the nine-slice quad generator, bound to the top level.
module nsq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input nsq_pkg::rsp_type                rsp_data
);

   // Last flag marks exactly the ninth quad, and no index runs past it.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_part == (rsp_data.part_index == nsq_pkg::LastPart))
                     && (rsp_data.part_index <= nsq_pkg::LastPart))
      else $error("quad index or last flag out of line");

   // A rendered quad has area.
   a_render_size: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.render) |-> (rsp_data.part_w != '0) && (rsp_data.part_h != '0))
      else $error("rendered quad with zero size");

   // Quads of one placement follow in order: a popped non-last quad is never
   // followed directly by a first quad.
   a_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_part) ##1 !rsp_empty
         |-> rsp_data.part_index == $past(rsp_data.part_index) + 4'd1)
      else $error("quad sequence broken");

   // A waiting word holds until popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_data))
      else $error("result word changed while stalled");

endmodule

bind nine_slice_quad_generator_unit nsq_checker u_nsq_checker (.*);
